/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on clk with synchronous reset rst; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CHK_IMPLY(label, ante, cons, msg)
`define CHK_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/core/rlgs_pkg.sv */
// ----------------------------------------------------------------------------
// rlgs_pkg
// Shared constants, request and register codes for the line gap scheduler.
// ----------------------------------------------------------------------------
package rlgs_pkg;

  localparam int MAX_LINES = 1024;
  localparam int LINE_W    = $clog2(MAX_LINES);
  localparam int CNT_W     = LINE_W + 1;
  localparam int TID_W     = 4;
  localparam int STEP_W    = 10;
  localparam int ITER_W    = $clog2(LINE_W + 1);

  localparam int REQ_W = 3;
  localparam logic [REQ_W-1:0] REQ_ASSIGN = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FINISH = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STATUS = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PASS   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 2'd2;

  localparam logic [CNT_W-1:0]  LINES_RESET = CNT_W'(MAX_LINES);
  localparam logic [STEP_W-1:0] STEP_RESET  = STEP_W'(1);

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 40;

endpackage

/* rtl/core/rlgs_ram.sv */
// ----------------------------------------------------------------------------
// rlgs_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rlgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/rlgs_round.sv */
// ----------------------------------------------------------------------------
// rlgs_round
// Round a line number down to a multiple of the step, one remainder bit a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlgs_round import rlgs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [LINE_W-1:0] mid,
  input  logic [STEP_W-1:0] step,
  output logic              busy,
  output logic              done,
  output logic [LINE_W-1:0] value
);

  logic [ITER_W-1:0] iter;
  logic [LINE_W-1:0] quo;
  logic [LINE_W-1:0] mid_r;
  logic [STEP_W-1:0] div;
  logic [STEP_W-1:0] rem;
  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   diff;
  logic              fits;
  logic [STEP_W-1:0] rem_next;

  assign trial    = {rem, quo[LINE_W-1]};
  assign diff     = trial - {1'b0, div};
  assign fits     = trial >= {1'b0, div};
  assign rem_next = fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
  assign value    = mid_r - LINE_W'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        iter  <= ITER_W'(LINE_W);
        quo   <= mid;
        mid_r <= mid;
        div   <= step;
        rem   <= '0;
      end else if (busy) begin
        rem  <= rem_next;
        quo  <= quo << 1;
        iter <= iter - ITER_W'(1);
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `CHK_IMPLY(a_rem_below_step, busy, rem < div, "remainder not below step")
  `CHK_IMPLY(a_round_not_above, done, value <= mid_r, "rounded line above middle")
  `CHK_NEXT(a_done_single, done, !done, "done held past one cycle")

endmodule

/* rtl/core/render_line_gap_scheduler.sv */
// ----------------------------------------------------------------------------
// render_line_gap_scheduler
// Hands image lines to worker threads; owner ids and done marks in two RAMs.
// ----------------------------------------------------------------------------
// Assign and unknown requests answer without a scan; status scans the n lines in use;
//   finish takes the line one step ahead when it is free, otherwise it scans the owner
//   RAM and rounds the middle of the widest free gap down to a multiple of the step.
// Clear and next pass (when the halved step is not zero) sweep all 1024 RAM entries.
// One request at a time; n is the number of lines in use.
// Reset (rst, synchronous) runs a clearing sweep over all 1024 entries with s_tready low.
`include "assert_macros.svh"

module render_line_gap_scheduler import rlgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // thread_id[3:0], line[13:4], zero[15:14]
  input  logic [REQ_W-1:0]      s_tuser,   // req_type[2:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata    // next_line[9:0], next_valid[10],
                                           // should_break[11], thread_has_work[12],
                                           // all_done[13], done_count[24:14],
                                           // more_passes[25], current_step[35:26],
                                           // zero[39:36]
);

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_ASSIGN     = 4'd2;
  localparam logic [3:0] S_MARK       = 4'd3;
  localparam logic [3:0] S_CHECK      = 4'd4;
  localparam logic [3:0] S_CHECK_WAIT = 4'd5;
  localparam logic [3:0] S_SCAN       = 4'd6;
  localparam logic [3:0] S_ROUND      = 4'd7;
  localparam logic [3:0] S_PICK       = 4'd8;
  localparam logic [3:0] S_STAT       = 4'd9;
  localparam logic [3:0] S_RESP       = 4'd10;

  logic [3:0]        state;
  logic [CNT_W-1:0]  lines_in_use;
  logic              stop_request;
  logic [STEP_W-1:0] step_now;

  logic [REQ_W-1:0]  req_r;
  logic [TID_W-1:0]  tid_r;
  logic [LINE_W-1:0] line_r;
  logic [CNT_W-1:0]  cnt;
  logic              clr_resp;

  logic              rd_v;
  logic [LINE_W-1:0] rd_idx;
  logic              in_gap;
  logic [LINE_W-1:0] gap_start;
  logic [LINE_W-1:0] widest;
  logic [LINE_W-1:0] best_mid;
  logic              found;
  logic [LINE_W-1:0] pick;
  logic              pick_valid;
  logic [TID_W-1:0]  owner_hit;
  logic              work;
  logic              all_seen;
  logic [CNT_W-1:0]  done_cnt;
  logic              more;

  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  mark_addr;
  logic [CNT_W-1:0]  tgt;
  logic              accept;
  logic              issue;
  logic              scan_end;
  logic              last;
  logic [LINE_W-1:0] gap_w;
  logic [CNT_W-1:0]  gap_sum;
  logic [STEP_W-1:0] step_half;
  logic              out_free;

  logic              own_we;
  logic [LINE_W-1:0] own_waddr;
  logic [TID_W-1:0]  own_wdata;
  logic [LINE_W-1:0] own_raddr;
  logic [TID_W-1:0]  own_rd;
  logic              done_we;
  logic [LINE_W-1:0] done_waddr;
  logic              done_wdata;
  logic              done_rd;

  logic              rnd_start;
  logic              rnd_busy;
  logic              rnd_done;
  logic [LINE_W-1:0] rnd_value;

  logic              is_stat;
  logic [LINE_W-1:0] o_line;
  logic              o_brk;
  logic              o_work;
  logic              o_all;
  logic [CNT_W-1:0]  o_cnt;

  assign n_eff     = (lines_in_use > CNT_W'(MAX_LINES)) ? CNT_W'(MAX_LINES) : lines_in_use;
  assign mark_addr = {1'b0, line_r} + cnt;
  assign tgt       = {1'b0, line_r} + CNT_W'(step_now);
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign issue     = ((state == S_SCAN) || (state == S_STAT)) && (cnt < n_eff);
  assign scan_end  = (cnt >= n_eff) && !rd_v;
  assign last      = ({1'b0, rd_idx} == (n_eff - CNT_W'(1)));
  assign gap_w     = rd_idx - gap_start;
  assign gap_sum   = {1'b0, rd_idx} + {1'b0, gap_start};
  assign step_half = step_now >> 1;
  assign out_free  = !m_tvalid || m_tready;
  assign rnd_start = (state == S_SCAN) && scan_end && found;

  // RAM port selection
  always_comb begin
    own_we     = 1'b0;
    own_waddr  = cnt[LINE_W-1:0];
    own_wdata  = '0;
    done_we    = 1'b0;
    done_waddr = cnt[LINE_W-1:0];
    done_wdata = 1'b0;
    own_raddr  = cnt[LINE_W-1:0];
    case (state)
      S_CLEAR: begin
        own_we  = 1'b1;
        done_we = 1'b1;
      end
      S_ASSIGN: begin
        own_we    = {1'b0, line_r} < n_eff;
        own_waddr = line_r;
        own_wdata = tid_r;
      end
      S_MARK: begin
        done_we    = (cnt < CNT_W'(step_now)) && (mark_addr < n_eff);
        done_waddr = mark_addr[LINE_W-1:0];
        done_wdata = 1'b1;
      end
      S_CHECK: begin
        own_raddr = tgt[LINE_W-1:0];
      end
      S_PICK: begin
        own_we    = 1'b1;
        own_waddr = pick;
        own_wdata = tid_r;
      end
      default: begin
      end
    endcase
  end

  rlgs_ram #(.WIDTH(TID_W), .DEPTH(MAX_LINES)) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .raddr (own_raddr),
    .rdata (own_rd)
  );

  rlgs_ram #(.WIDTH(1), .DEPTH(MAX_LINES)) u_done_ram (
    .clk   (clk),
    .we    (done_we),
    .waddr (done_waddr),
    .wdata (done_wdata),
    .raddr (cnt[LINE_W-1:0]),
    .rdata (done_rd)
  );

  rlgs_round u_round (
    .clk   (clk),
    .rst   (rst),
    .start (rnd_start),
    .mid   (best_mid),
    .step  (step_now),
    .busy  (rnd_busy),
    .done  (rnd_done),
    .value (rnd_value)
  );

  // result word fields
  assign is_stat = (req_r == REQ_STATUS);
  assign o_line  = pick_valid ? pick : '0;
  assign o_brk   = is_stat & ((owner_hit != tid_r) | stop_request);
  assign o_work  = is_stat & work & ~stop_request;
  assign o_all   = is_stat & (all_seen | stop_request);
  assign o_cnt   = is_stat ? done_cnt : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      lines_in_use <= LINES_RESET;
      stop_request <= 1'b0;
      step_now     <= STEP_RESET;
      cnt          <= '0;
      clr_resp     <= 1'b0;
      rd_v         <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      rd_v   <= issue;
      rd_idx <= cnt[LINE_W-1:0];
      if ((state == S_RESP) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_wen) begin
        unique case (cfg_addr)
          CFG_LINES: lines_in_use <= cfg_wdata;
          CFG_STEP:  step_now     <= cfg_wdata[STEP_W-1:0];
          CFG_STOP:  stop_request <= cfg_wdata[0];
          default: begin
          end
        endcase
      end

      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(MAX_LINES - 1)) begin
            state <= clr_resp ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_r      <= s_tuser;
            tid_r      <= s_tdata[TID_W-1:0];
            line_r     <= s_tdata[TID_W +: LINE_W];
            cnt        <= '0;
            clr_resp   <= 1'b1;
            pick_valid <= 1'b0;
            more       <= 1'b0;
            owner_hit  <= '0;
            work       <= 1'b0;
            all_seen   <= 1'b1;
            done_cnt   <= '0;
            case (s_tuser)
              REQ_ASSIGN: state <= S_ASSIGN;
              REQ_FINISH: state <= (step_now == '0) ? S_RESP : S_MARK;
              REQ_STATUS: state <= S_STAT;
              REQ_PASS: begin
                step_now <= step_half;
                if (step_half != '0) begin
                  more  <= 1'b1;
                  state <= S_CLEAR;
                end else begin
                  state <= S_RESP;
                end
              end
              REQ_CLEAR: state <= S_CLEAR;
              default:   state <= S_RESP;
            endcase
          end
        end
        S_ASSIGN: state <= S_RESP;
        S_MARK: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(step_now)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          cnt    <= '0;
          in_gap <= 1'b0;
          widest <= '0;
          found  <= 1'b0;
          state  <= (tgt < n_eff) ? S_CHECK_WAIT : S_SCAN;
        end
        S_CHECK_WAIT: begin
          if (own_rd == '0) begin
            pick  <= tgt[LINE_W-1:0];
            state <= S_PICK;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (rd_v) begin
            if (!in_gap && (own_rd == '0)) begin
              in_gap    <= 1'b1;
              gap_start <= rd_idx;
            end else if (in_gap && ((own_rd != '0) || last)) begin
              in_gap <= 1'b0;
              if (gap_w > widest) begin
                widest   <= gap_w;
                best_mid <= gap_sum[CNT_W-1:1];
                found    <= 1'b1;
              end
            end
          end
          if (scan_end) begin
            state <= found ? S_ROUND : S_RESP;
          end
        end
        S_ROUND: begin
          if (rnd_done) begin
            pick  <= rnd_value;
            state <= S_PICK;
          end
        end
        S_PICK: begin
          pick_valid <= 1'b1;
          state      <= S_RESP;
        end
        S_STAT: begin
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (rd_v) begin
            if (rd_idx == line_r) begin
              owner_hit <= own_rd;
            end
            if (done_rd) begin
              done_cnt <= done_cnt + CNT_W'(1);
            end else begin
              all_seen <= 1'b0;
              if (own_rd == tid_r) begin
                work <= 1'b1;
              end
            end
          end
          if (scan_end) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            m_tdata  <= {4'b0, step_now, more, o_cnt, o_all, o_work, o_brk,
                         pick_valid, o_line};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPLY(a_pick_in_range, state == S_PICK, CNT_W'(pick) < n_eff, "line given beyond lines in use")
  `CHK_IMPLY(a_idle_drained, state == S_IDLE, !rd_v && !rnd_busy, "read pipeline busy in idle")
  `CHK_NEXT(a_round_runs, rnd_start, rnd_busy && (state == S_ROUND), "rounding did not start")
  `CHK_IMPLY(a_word_from_resp, $rose(m_tvalid), $past(state) == S_RESP, "result word outside response")

endmodule

/* sim/render_line_gap_scheduler_tb.sv */
// ----------------------------------------------------------------------------
// render_line_gap_scheduler_tb
// Self-checking bench for the line gap scheduler. A scoreboard class carries
// its own copy of the owner and done tables, the step and the registers, and
// predicts the result word of every accepted request. A short directed run
// hits the table edges and corner requests, then random phases run with
// different line counts, steps and stop settings. Each phase applies its own
// mix of sender gaps and receiver stalls, and some phases hold the receiver
// off for a long stretch.
// ----------------------------------------------------------------------------
module render_line_gap_scheduler_tb;
  import rlgs_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int TAIL_CYCLES = 2100;
  localparam int HOLD_CYCLES = 3000;
  localparam int SHOW_LIMIT  = 10;

  typedef struct packed {
    logic [M_TDATA_W-37:0] pad;
    logic [STEP_W-1:0]     current_step;
    logic                  more_passes;
    logic [CNT_W-1:0]      done_count;
    logic                  all_done;
    logic                  thread_has_work;
    logic                  should_break;
    logic                  next_valid;
    logic [LINE_W-1:0]     next_line;
  } sched_result_t;

  class line_sched_board;
    logic [TID_W-1:0]  owner_tab [MAX_LINES];
    bit                done_tab  [MAX_LINES];
    logic [STEP_W-1:0] step_now;
    logic [CFG_W-1:0]  lines_cfg;
    logic [STEP_W-1:0] first_step;
    bit                stop_on;
    sched_result_t     expected_q [$];
    logic [LINE_W-1:0] last_given [16];
    bit                holds_line [16];
    int                n_requests, n_checked, n_errors, n_given;

    function new();
      lines_cfg  = LINES_RESET;
      first_step = STEP_RESET;
      step_now   = STEP_RESET;
      stop_on    = 1'b0;
      n_requests = 0;
      n_checked  = 0;
      n_errors   = 0;
      n_given    = 0;
      foreach (holds_line[t]) holds_line[t] = 1'b0;
      wipe();
    endfunction

    function void wipe();
      foreach (owner_tab[i]) begin
        owner_tab[i] = '0;
        done_tab[i]  = 1'b0;
      end
    endfunction

    function int lines_active();
      return (lines_cfg > MAX_LINES) ? MAX_LINES : int'(lines_cfg);
    endfunction

    function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_LINES: lines_cfg = val;
        CFG_STEP: begin
          first_step = val[STEP_W-1:0];
          step_now   = first_step;
        end
        CFG_STOP: stop_on = val[0];
        default: ;
      endcase
    endfunction

    // mark the finished run done, then pick the line ahead or the widest gap
    function bit hand_out(logic [TID_W-1:0] tid, int row, output int pick);
      int n, stp, gap_start, widest, choice;
      bit found, in_gap;
      n = lines_active();
      stp = int'(step_now);
      found = 1'b0;
      in_gap = 1'b0;
      gap_start = 0;
      widest = 0;
      choice = 0;
      pick = 0;
      if (stp == 0) return 1'b0;
      for (int i = 0; i < stp; i++)
        if (row + i < n) done_tab[row + i] = 1'b1;
      if (row + stp < n && owner_tab[row + stp] == '0) begin
        choice = row + stp;
        found = 1'b1;
      end else begin
        for (int i = 0; i < n; i++) begin
          if (!in_gap && owner_tab[i] == '0) begin
            in_gap = 1'b1;
            gap_start = i;
          end else if (in_gap && (owner_tab[i] != '0 || i == n - 1)) begin
            in_gap = 1'b0;
            if (i - gap_start > widest) begin
              widest = i - gap_start;
              choice = ((i + gap_start) / 2) / stp * stp;
              found = 1'b1;
            end
          end
        end
      end
      if (!found) return 1'b0;
      owner_tab[choice] = tid;
      pick = choice;
      return 1'b1;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [TID_W-1:0] tid,
                               logic [LINE_W-1:0] row_in);
      sched_result_t r;
      int n, row, pick, count;
      logic [TID_W-1:0] owner;
      bit work, all;
      r = '0;
      n = lines_active();
      row = int'(row_in);
      case (req)
        REQ_ASSIGN: if (row < n) owner_tab[row] = tid;
        REQ_FINISH: begin
          if (hand_out(tid, row, pick)) begin
            r.next_line  = LINE_W'(pick);
            r.next_valid = 1'b1;
            last_given[tid] = LINE_W'(pick);
            holds_line[tid] = 1'b1;
            n_given++;
          end
        end
        REQ_STATUS: begin
          owner = (row < n) ? owner_tab[row] : '0;
          work = 1'b0;
          all = 1'b1;
          count = 0;
          for (int i = 0; i < n; i++) begin
            if (done_tab[i]) begin
              count++;
            end else begin
              all = 1'b0;
              if (owner_tab[i] == tid) work = 1'b1;
            end
          end
          r.should_break    = (owner != tid) || stop_on;
          r.thread_has_work = work && !stop_on;
          r.all_done        = all || stop_on;
          r.done_count      = CNT_W'(count);
        end
        REQ_PASS: begin
          step_now = step_now >> 1;
          if (step_now != '0) begin
            wipe();
            r.more_passes = 1'b1;
          end
        end
        REQ_CLEAR: wipe();
        default: ;
      endcase
      r.current_step = step_now;
      expected_q.push_back(r);
      n_requests++;
    endfunction

    function string show(sched_result_t r);
      return $sformatf("line=%0d v=%0d brk=%0d work=%0d all=%0d cnt=%0d more=%0d step=%0d pad=%0h",
                       r.next_line, r.next_valid, r.should_break, r.thread_has_work,
                       r.all_done, r.done_count, r.more_passes, r.current_step, r.pad);
    endfunction

    function void check_word(logic [M_TDATA_W-1:0] word);
      sched_result_t got, want;
      got = word;
      n_checked++;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= SHOW_LIMIT)
          $display("[%0t] unexpected result word: %s", $realtime, show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        n_errors++;
        if (n_errors <= SHOW_LIMIT) begin
          $display("[%0t] result mismatch", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [REQ_W-1:0]     s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  line_sched_board board;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int n_settings     = 0;

  render_line_gap_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("render_line_gap_scheduler regression: fail");
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata);
  end

  task automatic write_regs(input logic [CFG_W-1:0] lines, input logic [CFG_W-1:0] step,
                            input logic [CFG_W-1:0] stop);
    logic [CFG_IDX_W-1:0] addr_list [3];
    logic [CFG_W-1:0]     val_list  [3];
    addr_list = '{CFG_LINES, CFG_STEP, CFG_STOP};
    val_list  = '{lines, step, stop};
    cfg_wen <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_addr  <= addr_list[k];
      cfg_wdata <= val_list[k];
      @(posedge clk);
      board.apply_cfg(addr_list[k], val_list[k]);
      @(negedge clk);
    end
    cfg_wen <= 1'b0;
    n_settings++;
  endtask

  task automatic send_req(input logic [REQ_W-1:0] req, input logic [TID_W-1:0] tid,
                          input logic [LINE_W-1:0] row);
    bit took;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= S_TDATA_W'({row, tid});
    do begin
      @(posedge clk);
      took = s_tready;
      if (took) board.note_request(req, tid, row);
      @(negedge clk);
    end while (!took);
  endtask

  // drop valid and wait for every pending result
  task automatic settle();
    s_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [LINE_W-1:0] rand_row(int n);
    if (n > 0 && $urandom_range(9) < 8) return LINE_W'($urandom_range(n - 1));
    return LINE_W'($urandom_range(MAX_LINES - 1));
  endfunction

  task automatic send_random();
    int kind, n;
    logic [REQ_W-1:0]  req;
    logic [TID_W-1:0]  tid;
    logic [LINE_W-1:0] row;
    n = board.lines_active();
    tid = TID_W'($urandom_range(15));
    kind = $urandom_range(99);
    if (board.holds_line[tid] && $urandom_range(9) < 7) row = board.last_given[tid];
    else row = rand_row(n);
    if (kind < 45) req = REQ_FINISH;
    else if (kind < 65) req = REQ_STATUS;
    else if (kind < 85) begin
      req = REQ_ASSIGN;
      row = rand_row(n);
    end else if (kind < 88) req = REQ_PASS;
    else if (kind < 91) req = REQ_CLEAR;
    else req = REQ_W'($urandom_range(7, 5));
    send_req(req, tid, row);
  endtask

  task automatic run_phase(input int lines, input int step, input int stop,
                           input int idle_s, input int idle_r, input int count,
                           input bit hold);
    settle();
    write_regs(CFG_W'(lines), CFG_W'(step), CFG_W'(stop));
    send_idle_pct  = idle_s;
    recv_stall_pct = idle_r;
    if (hold) hold_left = HOLD_CYCLES;
    repeat (count) send_random();
  endtask

  initial begin
    board     = new();
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    while (!s_tready) @(negedge clk);

    // full table, unit step
    write_regs(CFG_W'(MAX_LINES), CFG_W'(1), CFG_W'(0));
    send_req(REQ_ASSIGN, 4'd15, 10'd0);
    send_req(REQ_ASSIGN, 4'd1, 10'd1023);
    send_req(REQ_STATUS, 4'd15, 10'd0);
    send_req(REQ_FINISH, 4'd15, 10'd0);
    send_req(REQ_FINISH, 4'd1, 10'd1023);
    send_req(REQ_STATUS, 4'd0, 10'd1023);
    send_req(REQ_W'(5), 4'd0, 10'd0);
    send_req(REQ_W'(7), 4'd15, 10'd1023);
    send_req(REQ_CLEAR, 4'd0, 10'd0);
    send_req(REQ_PASS, 4'd2, 10'd3);
    send_req(REQ_FINISH, 4'd3, 10'd5);
    settle();

    // two lines, both owned: no free line; out-of-range assign and status
    write_regs(CFG_W'(2), CFG_W'(1), CFG_W'(0));
    send_req(REQ_ASSIGN, 4'd1, 10'd0);
    send_req(REQ_ASSIGN, 4'd2, 10'd1);
    send_req(REQ_ASSIGN, 4'd9, 10'd700);
    send_req(REQ_FINISH, 4'd1, 10'd0);
    send_req(REQ_STATUS, 4'd9, 10'd700);
    settle();

    // no lines in use, stop forced
    write_regs(CFG_W'(0), CFG_W'(2), CFG_W'(1));
    send_req(REQ_FINISH, 4'd4, 10'd0);
    send_req(REQ_STATUS, 4'd4, 10'd0);
    settle();

    // line count above the table size, widest step
    write_regs(CFG_W'(2047), CFG_W'(1023), CFG_W'(0));
    send_req(REQ_FINISH, 4'd6, 10'd0);
    send_req(REQ_STATUS, 4'd6, 10'd1023);
    send_req(REQ_PASS, 4'd6, 10'd0);
    send_req(REQ_W'(6), 4'd8, 10'd512);

    run_phase(16,   1,   0, 0,  0,  110, 1'b0);
    run_phase(64,   8,   0, 68, 0,  100, 1'b0);
    run_phase(37,   4,   1, 0,  68, 90,  1'b1);
    run_phase(200,  16,  0, 20, 20, 90,  1'b0);
    run_phase(1024, 512, 0, 0,  0,  40,  1'b0);
    run_phase(1,    1,   0, 68, 0,  40,  1'b0);
    run_phase(8,    3,   0, 20, 20, 70,  1'b1);
    settle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d requests under %0d register settings, %0d lines handed out",
             board.n_requests, n_settings, board.n_given);
    $display("checked %0d result words, %0d failures", board.n_checked, board.n_errors);
    if (board.n_errors == 0 && board.expected_q.size() == 0) begin
      $display("render_line_gap_scheduler regression: pass");
    end else begin
      $display("render_line_gap_scheduler regression: fail");
    end
    $finish;
  end

endmodule
